// ----- rtl/core/mf_pkg.sv -----
// Shared types, constants and compare helpers for the 3x3 median filter.
package mf_pkg;

  localparam int PIX_W        = 8;
  localparam int ROW_W        = 12;
  localparam int COL_W        = 11;
  localparam int WIDTH_REG_W  = 12;
  localparam int HEIGHT_REG_W = 13;
  localparam int CFG_IDX_W    = 8;
  localparam int CFG_DATA_W   = 13;
  localparam int WIN_COLS     = 3;
  localparam int MIN_SIZE     = 3;
  localparam int RST_WIDTH    = 640;
  localparam int RST_HEIGHT   = 480;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

  typedef logic [PIX_W-1:0] pix_t;

  typedef struct packed {
    pix_t pixel_value;
    logic frame_start;
  } in_t;

  typedef struct packed {
    pix_t             median_value;
    logic [ROW_W-1:0] center_row;
    logic [COL_W-1:0] center_col;
    logic             frame_last;
  } out_t;

  // One window column, held in ascending order.
  typedef struct packed {
    pix_t lo;
    pix_t md;
    pix_t hi;
  } col_t;

  // Partial results over the three sorted columns.
  typedef struct packed {
    pix_t lo_max;
    pix_t md_med;
    pix_t hi_min;
  } merge_t;

  // Position information that travels alongside a pending result.
  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
  } meta_t;

  function automatic pix_t min2(input pix_t a, input pix_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic pix_t max2(input pix_t a, input pix_t b);
    return (a > b) ? a : b;
  endfunction

  function automatic pix_t min3(input pix_t a, input pix_t b, input pix_t c);
    return min2(min2(a, b), c);
  endfunction

  function automatic pix_t max3(input pix_t a, input pix_t b, input pix_t c);
    return max2(max2(a, b), c);
  endfunction

  function automatic pix_t med3(input pix_t a, input pix_t b, input pix_t c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

  function automatic col_t sort3(input pix_t a, input pix_t b, input pix_t c);
    col_t s;
    s.lo = min3(a, b, c);
    s.md = med3(a, b, c);
    s.hi = max3(a, b, c);
    return s;
  endfunction

endpackage

// ----- rtl/core/mf_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module mf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/core/mf_cell.sv -----
// One window cell: holds a sorted column and passes it on when the window shifts.
module mf_cell (
  input  logic         clk,
  input  logic         shift,
  input  mf_pkg::col_t din,
  output mf_pkg::col_t dout
);
  import mf_pkg::*;

  col_t col_r;

  always_ff @(posedge clk) begin
    if (shift) begin
      col_r <= din;
    end
  end

  assign dout = col_r;

endmodule

// ----- rtl/core/mf_merge.sv -----
// Combines the three sorted window columns into the three median candidates.
module mf_merge (
  input  logic           clk,
  input  logic           load,
  input  mf_pkg::col_t   win [mf_pkg::WIN_COLS],
  output mf_pkg::merge_t cand
);
  import mf_pkg::*;

  merge_t cand_r;
  merge_t cand_nxt;

  // The largest column minimum, the median of the column medians and the
  // smallest column maximum bracket the true median of all nine values.
  always_comb begin
    cand_nxt.lo_max = max3(win[0].lo, win[1].lo, win[2].lo);
    cand_nxt.md_med = med3(win[0].md, win[1].md, win[2].md);
    cand_nxt.hi_min = min3(win[0].hi, win[1].hi, win[2].hi);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cand_r <= cand_nxt;
    end
  end

  assign cand = cand_r;

endmodule

// ----- rtl/core/median_filter_3x3.sv -----
// Top level of the 3x3 median filter over a raster pixel stream.
//
// Pixels enter on the in_ channel one request at a time, in raster order;
// frame_start marks row 0, column 0 and forces the position counters to zero.
// For every pixel at row r >= 2 and column c >= 2 one result request leaves on
// the out_ channel: the median of the 3x3 neighborhood centered on (r-1, c-1),
// that center position, and frame_last on the last interior pixel of a frame.
// Border pixels produce no result. Image width and height are written through
// the cfg_ port (index 0 width, index 1 height); values are clamped to the
// supported range and should only be changed while the filter is idle.
//
// Throughput is one pixel per clock while the receiver does not stall. For a pixel
// completing a window, the edge that accepts it starts the line store read; after
// that the column shifts into the cell chain, the merge candidates are loaded and
// the median is loaded into the output register, raising out_valid. The rate is set
// by the single line-store RAM, which is read and rewritten once per pixel. When
// the receiver stalls, the output register holds its result and the stages behind
// it keep filling until they are full; only then is in_stall raised. Reset clears
// all valid flags and the position counters and restores the default 640 x 480
// size; line stores need no clearing.
module median_filter_3x3 #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  mf_pkg::in_t                     in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output mf_pkg::out_t                    out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mf_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import mf_pkg::*;

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int RAM_W = 2 * PIX_W;
  localparam int W_RST = (RST_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RST_WIDTH;
  localparam int H_RST = (RST_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RST_HEIGHT;

  // ---------------------------------------------------------------------
  // Configuration registers. The port never pushes back.
  // ---------------------------------------------------------------------
  logic [WIDTH_REG_W-1:0]  width_r, width_nxt;
  logic [HEIGHT_REG_W-1:0] height_r, height_nxt;
  logic [WIDTH_REG_W-1:0]  cfg_w;
  logic [HEIGHT_REG_W-1:0] cfg_h;

  assign cfg_ready = 1'b1;
  assign cfg_w     = cfg_data[WIDTH_REG_W-1:0];
  assign cfg_h     = cfg_data[HEIGHT_REG_W-1:0];

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH: begin
          if (32'(cfg_w) < MIN_SIZE) begin
            width_nxt = WIDTH_REG_W'(MIN_SIZE);
          end else if (32'(cfg_w) > MAX_WIDTH) begin
            width_nxt = WIDTH_REG_W'(MAX_WIDTH);
          end else begin
            width_nxt = cfg_w;
          end
        end
        REG_IMAGE_HEIGHT: begin
          if (32'(cfg_h) < MIN_SIZE) begin
            height_nxt = HEIGHT_REG_W'(MIN_SIZE);
          end else if (32'(cfg_h) > MAX_HEIGHT) begin
            height_nxt = HEIGHT_REG_W'(MAX_HEIGHT);
          end else begin
            height_nxt = cfg_h;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Flow control. Each stage may load when it is empty or when the stage
  // after it is moving, so bubbles are squeezed out behind a stall.
  // ---------------------------------------------------------------------
  logic v1_r, v1_nxt;     // pixel waiting for its line-store data
  logic va_r, va_nxt;     // cell chain holds a window that owes a result
  logic vb_r, vb_nxt;     // merge candidates hold a pending result
  logic out_valid_r, out_valid_nxt;
  logic out_ld, en_b, en_a, s1_adv, accept;

  assign out_ld   = !out_valid_r || !out_stall;
  assign en_b     = !vb_r || out_ld;
  assign en_a     = !va_r || en_b;
  assign s1_adv   = v1_r && en_a;
  assign in_stall = v1_r && !en_a;
  assign accept   = in_valid && !in_stall;

  // ---------------------------------------------------------------------
  // Position counters and decode of the incoming pixel.
  // ---------------------------------------------------------------------
  logic [CW-1:0] col_r, col_nxt, cur_col;
  logic [RW-1:0] row_r, row_nxt, cur_row;
  logic          cur_emit;
  meta_t         cur_meta;

  assign cur_col = in_data.frame_start ? '0 : col_r;
  assign cur_row = in_data.frame_start ? '0 : row_r;
  assign cur_emit = (32'(cur_row) >= 2) && (32'(cur_col) >= 2);

  always_comb begin
    cur_meta.row  = ROW_W'(cur_row - RW'(1));
    cur_meta.col  = COL_W'(cur_col - CW'(1));
    cur_meta.last = (32'(cur_row) == 32'(height_r) - 1) &&
                    (32'(cur_col) == 32'(width_r) - 1);
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (32'(cur_col) + 1 >= 32'(width_r)) begin
        col_nxt = '0;
        row_nxt = (32'(cur_row) + 1 >= 32'(height_r)) ? '0 : cur_row + RW'(1);
      end else begin
        col_nxt = cur_col + CW'(1);
        row_nxt = cur_row;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Line store. Each word holds {upper line, middle line} for one column.
  // The word is read when the pixel is accepted and rewritten when it moves
  // into the window; a read of the word in the cycle it is rewritten is forwarded.
  // ---------------------------------------------------------------------
  pix_t            px1_r;
  logic [CW-1:0]   addr1_r;
  logic            emit1_r;
  meta_t           meta1_r;
  logic [RAM_W-1:0] ram_rdata, ram_wdata;
  logic             byp_r;
  logic [RAM_W-1:0] byp_data_r;
  logic [RAM_W-1:0] line_word;
  pix_t             up_pix, mid_pix;
  col_t             new_col;

  assign line_word = byp_r ? byp_data_r : ram_rdata;
  assign up_pix    = line_word[RAM_W-1:PIX_W];
  assign mid_pix   = line_word[PIX_W-1:0];
  assign ram_wdata = {mid_pix, px1_r};
  assign new_col   = sort3(up_pix, mid_pix, px1_r);

  mf_ram #(
    .WIDTH (RAM_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (addr1_r),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (cur_col),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      px1_r      <= in_data.pixel_value;
      addr1_r    <= cur_col;
      emit1_r    <= cur_emit;
      meta1_r    <= cur_meta;
      byp_data_r <= ram_wdata;
    end
  end

  // ---------------------------------------------------------------------
  // Window: a chain of cells, each holding one sorted column. The newest
  // column enters cell 0 and the oldest falls out of the last cell.
  // ---------------------------------------------------------------------
  col_t  win [WIN_COLS];
  meta_t meta_a_r;

  for (genvar i = 0; i < WIN_COLS; i++) begin : g_cell
    if (i == 0) begin : g_head
      mf_cell u_cell (
        .clk   (clk),
        .shift (s1_adv),
        .din   (new_col),
        .dout  (win[i])
      );
    end else begin : g_body
      mf_cell u_cell (
        .clk   (clk),
        .shift (s1_adv),
        .din   (win[i-1]),
        .dout  (win[i])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      meta_a_r <= meta1_r;
    end
  end

  // ---------------------------------------------------------------------
  // Merge stage and final median selection.
  // ---------------------------------------------------------------------
  merge_t cand;
  meta_t  meta_b_r;
  logic   ld_b;
  out_t   out_data_r;

  assign ld_b = en_b && va_r;

  mf_merge u_merge (
    .clk  (clk),
    .load (ld_b),
    .win  (win),
    .cand (cand)
  );

  always_ff @(posedge clk) begin
    if (ld_b) begin
      meta_b_r <= meta_a_r;
    end
    if (out_ld && vb_r) begin
      out_data_r.median_value <= med3(cand.lo_max, cand.md_med, cand.hi_min);
      out_data_r.center_row   <= meta_b_r.row;
      out_data_r.center_col   <= meta_b_r.col;
      out_data_r.frame_last   <= meta_b_r.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------------------------------------------------------------
  // Valid flags.
  // ---------------------------------------------------------------------
  always_comb begin
    v1_nxt = v1_r;
    if (accept) begin
      v1_nxt = 1'b1;
    end else if (s1_adv) begin
      v1_nxt = 1'b0;
    end

    va_nxt = va_r;
    if (s1_adv) begin
      va_nxt = emit1_r;
    end else if (va_r && en_b) begin
      va_nxt = 1'b0;
    end

    vb_nxt = en_b ? va_r : vb_r;
    out_valid_nxt = out_ld ? vb_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r     <= WIDTH_REG_W'(W_RST);
      height_r    <= HEIGHT_REG_W'(H_RST);
      col_r       <= '0;
      row_r       <= '0;
      v1_r        <= 1'b0;
      va_r        <= 1'b0;
      vb_r        <= 1'b0;
      out_valid_r <= 1'b0;
      byp_r       <= 1'b0;
    end else begin
      width_r     <= width_nxt;
      height_r    <= height_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      v1_r        <= v1_nxt;
      va_r        <= va_nxt;
      vb_r        <= vb_nxt;
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        byp_r <= s1_adv && (addr1_r == cur_col);
      end
    end
  end

endmodule

// ----- tb/median_filter_3x3_checker.sv -----
`timescale 1ns / 100ps
// Scoreboard for the 3x3 median filter: predicts every median and checks the result channel.
module median_filter_3x3_checker #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  mf_pkg::in_t                   in_data,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  mf_pkg::out_t                  out_data,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [mf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mf_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                            fail_count,
  output int                            pending_count,
  output int                            checked_count
);
  import mf_pkg::*;

  pix_t       upper_line  [MAX_WIDTH];
  pix_t       middle_line [MAX_WIDTH];
  pix_t [8:0] window;
  int         row_pos, col_pos, width_set, height_set;
  out_t       expected_medians [$];
  int         errors = 0;
  int         checked = 0;

  function automatic int clamp_dim(input int v, input int hi);
    if (v < MIN_SIZE) return MIN_SIZE;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic report(input string msg);
    $display("%0t ns checker: %s", $time, msg);
    errors++;
  endtask

  always @(posedge clk) begin : scoreboard
    out_t got, want;
    int   r, c, below, not_above;
    pix_t up, mid, med;
    if (!rst_n) begin
      window     = '0;
      row_pos    = 0;
      col_pos    = 0;
      width_set  = clamp_dim(RST_WIDTH, MAX_WIDTH);
      height_set = clamp_dim(RST_HEIGHT, MAX_HEIGHT);
      expected_medians.delete();
    end else begin
      // Results are compared before this edge's pixel is predicted, so a stray result can
      // never be matched against an expectation made at the same edge.
      if (out_valid && !out_stall) begin
        got = out_data;
        if (expected_medians.size() == 0) begin
          report($sformatf("result with nothing expected: median %0d row %0d col %0d last %0b",
                           got.median_value, got.center_row, got.center_col, got.frame_last));
        end else begin
          want = expected_medians.pop_front();
          checked++;
          if (got.median_value !== want.median_value)
            report($sformatf("median %0d, expected %0d at row %0d col %0d", got.median_value,
                             want.median_value, want.center_row, want.center_col));
          if (got.center_row !== want.center_row)
            report($sformatf("center_row %0d, expected %0d", got.center_row, want.center_row));
          if (got.center_col !== want.center_col)
            report($sformatf("center_col %0d, expected %0d", got.center_col, want.center_col));
          if (got.frame_last !== want.frame_last)
            report($sformatf("frame_last %0b, expected %0b at row %0d col %0d", got.frame_last,
                             want.frame_last, want.center_row, want.center_col));
        end
      end

      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_IMAGE_WIDTH)
          width_set = clamp_dim(int'(cfg_data[WIDTH_REG_W-1:0]), MAX_WIDTH);
        else if (cfg_index == REG_IMAGE_HEIGHT)
          height_set = clamp_dim(int'(cfg_data[HEIGHT_REG_W-1:0]), MAX_HEIGHT);
      end

      if (in_valid && !in_stall) begin
        if (in_data.frame_start) begin
          row_pos = 0;
          col_pos = 0;
        end
        r = row_pos;
        c = (col_pos >= MAX_WIDTH) ? MAX_WIDTH - 1 : col_pos;
        up  = upper_line[c];
        mid = middle_line[c];
        window[0] = window[1];
        window[1] = window[2];
        window[2] = up;
        window[3] = window[4];
        window[4] = window[5];
        window[5] = mid;
        window[6] = window[7];
        window[7] = window[8];
        window[8] = in_data.pixel_value;
        upper_line[c]  = mid;
        middle_line[c] = in_data.pixel_value;

        if (r >= 2 && c >= 2) begin
          // The median is the value with at most four entries below it and at least five
          // entries at or below it.
          med = window[0];
          for (int i = 0; i < 9; i++) begin
            below     = 0;
            not_above = 0;
            for (int j = 0; j < 9; j++) begin
              if (window[j] < window[i]) below++;
              if (window[j] <= window[i]) not_above++;
            end
            if (below <= 4 && not_above >= 5) med = window[i];
          end
          want.median_value = med;
          want.center_row   = ROW_W'(r - 1);
          want.center_col   = COL_W'(c - 1);
          want.frame_last   = (r == height_set - 1) && (c == width_set - 1);
          expected_medians.insert(expected_medians.size(), want);
        end

        if (c + 1 >= width_set) begin
          col_pos = 0;
          row_pos = (r + 1 >= height_set) ? 0 : r + 1;
        end else begin
          col_pos = c + 1;
        end
      end
    end
    fail_count    <= errors;
    pending_count <= expected_medians.size();
    checked_count <= checked;
  end

endmodule

// ----- tb/median_filter_3x3_tb.sv -----
`timescale 1ns / 100ps
// Testbench top for the 3x3 median filter: clock, reset, stimulus, stalls and the verdict.
module median_filter_3x3_tb;
  import mf_pkg::*;

  localparam int MAX_WIDTH     = 2048;
  localparam int MAX_HEIGHT    = 4096;
  localparam int RANDOM_PIXELS = 400;
  // Cycles allowed after the last expected median for pixels that make no result
  // to leave the pipeline.
  localparam int SETTLE_CYCLES = 12;
  // The longest quiet stretch of a correct run is a sender gap, a settle pause or a run of
  // receiver stalls.
  localparam int WATCHDOG_LIMIT = 1000;

  // Indexes that do not name a register; writes to them must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LOW = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_TOP = CFG_IDX_W'(255);

  typedef enum int {STYLE_UNIFORM, STYLE_EXTREME, STYLE_FLAT, STYLE_RAMP} pixel_style_t;
  typedef enum int {FRAME_WHOLE, FRAME_CUT, FRAME_RESIZE} frame_kind_t;
  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_BURSTY} stall_mode_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_t                   in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_t                  out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int fail_count;
  int pending_count;
  int checked_count;

  int          burst_left     = 0;
  bit          steady_sender  = 1'b0;
  int          pixels_sent    = 0;
  int          settings_used  = 0;
  int          idle_cycles    = 0;
  int          stall_span     = 0;
  stall_mode_t stall_mode     = STALL_NONE;
  pix_t        level          = 8'd128;

  median_filter_3x3 #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  median_filter_3x3_checker #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) i_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .pending_count(pending_count),
    .checked_count(checked_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // The receiver changes its stall behavior after each span of random length: no stalls at all, light
  // or heavy random stalls, or regular runs of stalls. Because the spans are unrelated to the
  // sender's bursts, stalls land on every phase of the filter's work.
  always @(posedge clk) begin
    if (stall_span == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(0, 3));
      stall_span <= $urandom_range(16, 160);
    end else begin
      stall_span <= stall_span - 1;
    end
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 4) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 1) == 0);
      default:     out_stall <= (stall_span % 9 < 5);
    endcase
  end

  // Watchdog: a correct run never goes long without some request being accepted.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no request accepted for %0d cycles.", WATCHDOG_LIMIT);
      $display("median_filter_3x3_tb failed");
      $finish;
    end
  end

  // Offers one pixel request and returns at the edge that accepts it. The sender works in
  // bursts; between bursts it drops valid for a random gap unless it is in a steady stretch.
  // Valid is only lowered when a gap really follows, so it is never dropped and raised again
  // within one time step.
  task automatic send_pixel(input pix_t value, input logic start);
    int  gap;
    in_t item;
    if (burst_left == 0) begin
      gap = steady_sender ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 48);
    end
    item.pixel_value = value;
    item.frame_start = start;
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    burst_left--;
    pixels_sent++;
  endtask

  // Sends a run of pixels in one of several content styles: uniform noise reaches every bit,
  // black and white extremes and a slowly drifting flat level give many ties in the window,
  // and a ramp gives ordered neighborhoods.
  task automatic send_stream(input int count, input bit first_start, input pixel_style_t style);
    pix_t value;
    for (int k = 0; k < count; k++) begin
      case (style)
        STYLE_EXTREME: value = $urandom_range(0, 1) ? 8'hff : 8'h00;
        STYLE_FLAT: begin
          level = level + pix_t'($urandom_range(0, 2)) - pix_t'(1);
          value = level;
        end
        STYLE_RAMP: begin
          level = level + pix_t'(5);
          value = level;
        end
        default: value = pix_t'($urandom);
      endcase
      send_pixel(value, first_start && (k == 0));
    end
  endtask

  // Brings the filter to rest: the checker holds no expected median, and then the settle
  // pause passes so that pixels which produce no result have left the pipeline too.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes one register. Valid stays high into a following write; the caller marks the
  // last write of a sequence so valid is lowered exactly once.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input int value, input bit last);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= CFG_DATA_W'(value);
    do @(posedge clk); while (!cfg_ready);
    if (last) cfg_valid <= 1'b0;
  endtask

  task automatic set_size(input int width, input int height);
    wait_idle();
    write_reg(REG_IMAGE_WIDTH, width, 1'b0);
    write_reg(REG_IMAGE_HEIGHT, height, 1'b1);
    settings_used++;
  endtask

  initial begin : stimulus
    int           frame_w, frame_h, frame_len, split, directed_count;
    bit           first;
    pixel_style_t style;

    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Sizes below the minimum are taken as three, so this is a 3x3 frame with exactly one
    // interior pixel, which is also the last one of the frame.
    set_size(0, 2);
    // Alternating black and white: five blacks, so the median is black.
    for (int k = 0; k < 9; k++) send_pixel((k % 2 == 0) ? 8'h00 : 8'hff, k == 0);
    // The position wraps after the last line, so a frame may begin without frame_start.
    for (int k = 0; k < 9; k++) send_pixel((k % 4 == 2) ? 8'h00 : 8'hff, 1'b0);
    // A frame cut short: frame_start arrives in the middle and restarts the position.
    for (int k = 0; k < 3; k++) send_pixel(pix_t'($urandom), 1'b0);
    for (int k = 0; k < 9; k++) send_pixel(pix_t'($urandom), k == 0);

    // Sizes above the maximum are taken as the maximum; writes to other indexes are ignored.
    wait_idle();
    write_reg(REG_IMAGE_WIDTH, 4095, 1'b0);
    write_reg(REG_IMAGE_HEIGHT, 8191, 1'b0);
    write_reg(REG_UNUSED_LOW, 5, 1'b0);
    write_reg(REG_UNUSED_TOP, 8191, 1'b1);
    settings_used++;
    send_stream(40, 1'b1, STYLE_UNIFORM);
    // The largest sizes, written exactly, get only a few pixels each to keep the run short.
    set_size(3, MAX_HEIGHT);
    send_stream(120, 1'b1, STYLE_UNIFORM);
    set_size(MAX_WIDTH, 3);
    send_stream(60, 1'b1, STYLE_FLAT);
    directed_count = pixels_sent;

    // Random phases: a new small frame size, then one to three frames of mixed kinds. The
    // first pixel of a phase always carries frame_start, so no window ever reads a
    // line store entry that was never written. Within a phase the width only shrinks.
    while (pixels_sent - directed_count < RANDOM_PIXELS) begin
      frame_w = ($urandom_range(0, 5) == 0) ? 3 : $urandom_range(3, 24);
      frame_h = ($urandom_range(0, 5) == 0) ? 3 : $urandom_range(3, 9);
      steady_sender = ($urandom_range(0, 3) == 0);
      set_size(frame_w, frame_h);
      first = 1'b1;
      repeat ($urandom_range(1, 3)) begin
        style     = pixel_style_t'($urandom_range(0, 3));
        frame_len = frame_w * frame_h;
        case (frame_kind_t'($urandom_range(0, 2)))
          FRAME_CUT: begin
            // The next frame either restarts with frame_start or just carries on.
            send_stream($urandom_range(1, frame_len - 1), 1'b1, style);
          end
          FRAME_RESIZE: begin
            // Change the size in the middle of a frame, once the first line is complete.
            // The position is kept and wraps against the new size from then on.
            split = $urandom_range(frame_w, frame_len - 1);
            send_stream(split, 1'b1, style);
            wait_idle();
            if (frame_w > 3 && $urandom_range(0, 1) == 1) begin
              frame_w = $urandom_range(3, frame_w - 1);
              write_reg(REG_IMAGE_WIDTH, frame_w, 1'b1);
            end else begin
              frame_h = $urandom_range(3, 9);
              write_reg(REG_IMAGE_HEIGHT, frame_h, 1'b1);
            end
            send_stream($urandom_range(1, frame_w * frame_h), 1'b0, style);
          end
          default: begin
            send_stream(frame_len, first || ($urandom_range(0, 1) == 1), style);
          end
        endcase
        first = 1'b0;
      end
    end

    wait_idle();
    $display("Sent %0d pixels over %0d frame size settings, with cut, wrapped and resized frames.",
             pixels_sent, settings_used);
    $display("Compared %0d medians with %0d mismatches.", checked_count, fail_count);
    if (fail_count == 0) begin
      $display("median_filter_3x3_tb passed");
    end else begin
      $display("median_filter_3x3_tb failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/mf_pkg.sv
rtl/core/mf_ram.sv
rtl/core/mf_cell.sv
rtl/core/mf_merge.sv
rtl/core/median_filter_3x3.sv
tb/median_filter_3x3_checker.sv
tb/median_filter_3x3_tb.sv
